### src/tiff_strip_pixel_packer_core_assert.svh
// Assertion macros shared by the strip pixel packer RTL.
`ifndef TIFF_STRIP_PIXEL_PACKER_CORE_ASSERT_SVH
`define TIFF_STRIP_PIXEL_PACKER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TSPP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TSPP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tspp_pkg.sv
// Types, codes and palette tables of the strip pixel packer.
`default_nettype none
package tspp_pkg;

	localparam int CFG_W = 40;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [2:0] {
		MODE_BIT    = 3'd0,
		MODE_NIBBLE = 3'd1,
		MODE_ALPHA  = 3'd2,
		MODE_QUAD   = 3'd3,
		MODE_FULL   = 3'd4
	} pack_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PACK_MODE  = 3'd0,
		REG_ULTRA      = 3'd1,
		REG_CMYK       = 3'd2,
		REG_BG_ENTRY   = 3'd3,
		REG_FG_ENTRY   = 3'd4,
		REG_ROWS_STRIP = 3'd5
	} cfg_reg_t;

	localparam logic [7:0] CODE_ZERO = 8'h30;
	localparam logic [7:0] CODE_ONE  = 8'h31;
	localparam logic [7:0] CODE_W = 8'h57;
	localparam logic [7:0] CODE_C = 8'h43;
	localparam logic [7:0] CODE_B = 8'h42;
	localparam logic [7:0] CODE_M = 8'h4d;
	localparam logic [7:0] CODE_R = 8'h52;
	localparam logic [7:0] CODE_Y = 8'h59;
	localparam logic [7:0] CODE_G = 8'h47;
	localparam logic [7:0] CODE_K = 8'h4b;

	localparam logic [3:0] IDX_ULTRA_BG = 4'd8;
	localparam logic [3:0] IDX_ULTRA_FG = 4'd9;
	localparam logic [3:0] IDX_PLAIN_FG = 4'd1;

	localparam logic [7:0] FIXED_CMYK [8][4] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00}, '{8'hff, 8'h00, 8'h00, 8'h00},
		'{8'hff, 8'hff, 8'h00, 8'h00}, '{8'h00, 8'hff, 8'h00, 8'h00},
		'{8'h00, 8'hff, 8'hff, 8'h00}, '{8'h00, 8'h00, 8'hff, 8'h00},
		'{8'hff, 8'h00, 8'hff, 8'h00}, '{8'h00, 8'h00, 8'h00, 8'hff}
	};

	localparam logic [7:0] FIXED_RGB [8][3] = '{
		'{8'hff, 8'hff, 8'hff}, '{8'h00, 8'hff, 8'hff},
		'{8'h00, 8'h00, 8'hff}, '{8'hff, 8'h00, 8'hff},
		'{8'hff, 8'h00, 8'h00}, '{8'hff, 8'hff, 8'h00},
		'{8'h00, 8'hff, 8'h00}, '{8'h00, 8'h00, 8'h00}
	};

	// Configuration seen by the packing logic.
	typedef struct packed {
		logic [2:0]       mode;
		logic             ultra;
		logic             cmyk;
		logic [CFG_W-1:0] bg;
		logic [CFG_W-1:0] fg;
		logic [15:0]      strip_rows;
	} cfg_t;

	// Packer state, current or next.
	typedef struct packed {
		logic [7:0]  acc;
		logic [2:0]  pix;
		logic [15:0] rows;
	} pack_state_t;

	// Flags of the final byte that one pixel produces.
	typedef struct packed {
		logic row_end;
		logic strip_end;
	} end_flags_t;

	function automatic logic [3:0] code_to_index(input logic ultra, input logic [7:0] code);
		logic [3:0] r;
		if (ultra) begin
			case (code)
				CODE_W:   r = 4'd0;
				CODE_C:   r = 4'd1;
				CODE_B:   r = 4'd2;
				CODE_M:   r = 4'd3;
				CODE_R:   r = 4'd4;
				CODE_Y:   r = 4'd5;
				CODE_G:   r = 4'd6;
				CODE_K:   r = 4'd7;
				CODE_ONE: r = IDX_ULTRA_FG;
				default:  r = IDX_ULTRA_BG;
			endcase
		end else begin
			r = (code == CODE_ONE) ? IDX_PLAIN_FG : 4'd0;
		end
		return r;
	endfunction

	function automatic logic [7:0] palette_byte(input logic ultra, input logic cmyk,
			input logic [CFG_W-1:0] bg, input logic [CFG_W-1:0] fg,
			input logic [3:0] idx, input logic [2:0] k);
		logic [2:0]       apos;
		logic [CFG_W-1:0] e;
		logic [7:0]       r;
		apos = cmyk ? 3'd4 : 3'd3;
		if (ultra && !idx[3]) begin
			// Fixed colours: table below the alpha slot, foreground alpha at it.
			e = fg >> {k, 3'b000};
			if (k == apos)
				r = e[7:0];
			else if (k < apos)
				r = cmyk ? FIXED_CMYK[idx[2:0]][k[1:0]] : FIXED_RGB[idx[2:0]][k[1:0]];
			else
				r = 8'h00;
		end else begin
			if ((ultra && idx == IDX_ULTRA_FG) || (!ultra && idx == IDX_PLAIN_FG))
				e = fg >> {k, 3'b000};
			else
				e = bg >> {k, 3'b000};
			r = e[7:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### src/tspp_pack.sv
// Maps one pixel code to its strip bytes and the next packer state.
`default_nettype none
module tspp_pack #(
	parameter int MAX_SAMPLES = 5
) (
	input  tspp_pkg::cfg_t                          cfg,
	input  tspp_pkg::pack_state_t                   cur,
	input  logic [7:0]                              pixel_code,
	input  logic                                    row,
	input  logic                                    image_end,
	output tspp_pkg::pack_state_t                   nxt,
	output logic [MAX_SAMPLES-1:0][7:0]             bytes,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]        count,
	output tspp_pkg::end_flags_t                    flags
);
	import tspp_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic [3:0]  idx;
	logic [2:0]  apos;
	logic [2:0]  bitpos;
	logic [7:0]  acc_or;
	logic [15:0] rows_inc;
	logic        strip_done;

	assign idx    = code_to_index(cfg.ultra, pixel_code);
	assign apos   = cfg.cmyk ? 3'd4 : 3'd3;
	assign bitpos = 3'd7 - cur.pix;
	assign acc_or = cur.acc | (8'(idx[0]) << bitpos);

	// Completed rows advance the strip count only when a byte goes out.
	assign rows_inc   = cur.rows + 16'd1;
	assign strip_done = image_end || (rows_inc >= cfg.strip_rows);

	always_comb begin
		nxt.acc  = cur.acc;
		nxt.pix  = cur.pix;
		count    = '0;
		for (int k = 0; k < MAX_SAMPLES; k++)
			bytes[k] = palette_byte(cfg.ultra, cfg.cmyk, cfg.bg, cfg.fg, idx, 3'(k));
		case (cfg.mode)
			MODE_BIT: begin
				if (cur.pix == 3'd7 || row) begin
					bytes[0] = acc_or;
					count    = CW'(1);
					nxt.acc  = '0;
					nxt.pix  = '0;
				end else begin
					nxt.acc = acc_or;
					nxt.pix = cur.pix + 3'd1;
				end
			end
			MODE_NIBBLE: begin
				if (cur.pix == 3'd0) begin
					if (row) begin
						bytes[0] = {idx, 4'h0};
						count    = CW'(1);
						nxt.acc  = '0;
					end else begin
						nxt.acc = {idx, 4'h0};
						nxt.pix = 3'd1;
					end
				end else begin
					bytes[0] = cur.acc | {4'h0, idx};
					count    = CW'(1);
					nxt.acc  = '0;
					nxt.pix  = '0;
				end
			end
			MODE_ALPHA: begin
				bytes[0] = {4'h0, idx};
				bytes[1] = palette_byte(cfg.ultra, cfg.cmyk, cfg.bg, cfg.fg, idx, apos);
				count    = CW'(2);
			end
			MODE_QUAD: count = CW'(4);
			default:   count = CW'(MAX_SAMPLES);
		endcase
		nxt.rows        = cur.rows;
		flags.row_end   = 1'b0;
		flags.strip_end = 1'b0;
		if (count != '0 && row) begin
			flags.row_end   = 1'b1;
			flags.strip_end = strip_done;
			nxt.rows        = strip_done ? 16'd0 : rows_inc;
		end
	end

endmodule
`default_nettype wire

### src/tiff_strip_pixel_packer_core.sv
// Top level of the strip pixel packer: input stage, packer and byte burst output.
//
//  channel  dir  tdata               tuser                    tlast
//  s_*      in   [7:0] pixel_code    [0] last_in_image        last_in_row
//  m_*      out  [7:0] data_byte     [0] row_end [1] strip_end last
//  cfg_*    in   write enable cfg_we, register cfg_idx, value cfg_data
//
// A pixel produces 1 or 0 bytes in the packed modes, 2, 4 or MAX_SAMPLES in the
// byte modes. The byte burst register feeds one byte per cycle while m_tready
// is high.
// A pixel is registered, packed in the next cycle and its bytes loaded into the
// burst register while it is empty or the previous burst hands out its final byte.
// Reset clears all control state and the configuration; a stall on m_tready
// holds the current byte and backs up into s_tready once one more pixel that
// produces bytes waits in the input stage.
`default_nettype none
`include "tiff_strip_pixel_packer_core_assert.svh"
module tiff_strip_pixel_packer_core #(
	parameter int MAX_SAMPLES = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] pixel_code
	input  logic                           s_tlast,
	input  logic                           s_tuser,  // [0] last_in_image
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,  // [7:0] data_byte
	output logic                           m_tlast,
	output logic [1:0]                     m_tuser,  // [0] row_end, [1] strip_end
	input  logic                           cfg_we,
	input  logic [tspp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tspp_pkg::CFG_W-1:0]     cfg_data
);
	import tspp_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int IW = $clog2(MAX_SAMPLES);

	cfg_t        cfg_q;
	pack_state_t st_q;
	pack_state_t st_nxt;

	logic        v_s1;
	logic [7:0]  code_s1;
	logic        row_s1;
	logic        img_s1;

	logic [MAX_SAMPLES-1:0][7:0] bytes_c;
	logic [CW-1:0]               count_c;
	end_flags_t                  flags_c;

	logic                        v_s2;
	logic [MAX_SAMPLES-1:0][7:0] bytes_s2;
	logic [CW-1:0]               cnt_s2;
	end_flags_t                  flags_s2;
	logic [IW-1:0]               sel_q;

	logic last_byte;
	logic s2_done;
	logic s1_go;
	logic load_s2;
	logic in_xfer;

	// Configuration registers; a pack mode write drops any partial byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode       <= MODE_BIT;
			cfg_q.ultra      <= 1'b0;
			cfg_q.cmyk       <= 1'b0;
			cfg_q.bg         <= '0;
			cfg_q.fg         <= '0;
			cfg_q.strip_rows <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PACK_MODE:  cfg_q.mode       <= cfg_data[2:0];
				REG_ULTRA:      cfg_q.ultra      <= cfg_data[0];
				REG_CMYK:       cfg_q.cmyk       <= cfg_data[0];
				REG_BG_ENTRY:   cfg_q.bg         <= cfg_data;
				REG_FG_ENTRY:   cfg_q.fg         <= cfg_data;
				REG_ROWS_STRIP: cfg_q.strip_rows <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign last_byte = (CW'(sel_q) + CW'(1)) == cnt_s2;
	assign s2_done   = v_s2 && m_tready && last_byte;
	assign s1_go     = v_s1 && (count_c == '0 || !v_s2 || s2_done);
	assign load_s2   = s1_go && (count_c != '0);
	assign s_tready  = !v_s1 || s1_go;
	assign in_xfer   = s_tvalid && s_tready;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_xfer)
			v_s1 <= 1'b1;
		else if (s1_go)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			code_s1 <= s_tdata;
			row_s1  <= s_tlast | s_tuser;
			img_s1  <= s_tuser;
		end
	end

	tspp_pack #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_pack (
		.cfg        (cfg_q),
		.cur        (st_q),
		.pixel_code (code_s1),
		.row        (row_s1),
		.image_end  (img_s1),
		.nxt        (st_nxt),
		.bytes      (bytes_c),
		.count      (count_c),
		.flags      (flags_c)
	);

	// Packer state commits when the pixel leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (cfg_we && cfg_idx == REG_PACK_MODE) begin
			st_q.acc <= '0;
			st_q.pix <= '0;
		end else if (s1_go) begin
			st_q <= st_nxt;
		end
	end

	// Byte burst register and its read pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2  <= 1'b0;
			sel_q <= '0;
		end else if (load_s2) begin
			v_s2  <= 1'b1;
			sel_q <= '0;
		end else if (s2_done) begin
			v_s2  <= 1'b0;
		end else if (v_s2 && m_tready) begin
			sel_q <= sel_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			bytes_s2 <= bytes_c;
			cnt_s2   <= count_c;
			flags_s2 <= flags_c;
		end
	end

	assign m_tvalid   = v_s2;
	assign m_tdata    = bytes_s2[sel_q];
	assign m_tlast    = last_byte;
	assign m_tuser[0] = last_byte && flags_s2.row_end;
	assign m_tuser[1] = last_byte && flags_s2.strip_end;

	`TSPP_ASSERT_NOW(a_burst_len, clk, arst_n, v_s2,
		(cnt_s2 != '0) && (cnt_s2 <= CW'(MAX_SAMPLES)), "burst length out of range")
	`TSPP_ASSERT_NOW(a_strip_on_row, clk, arst_n, v_s2 && flags_s2.strip_end,
		flags_s2.row_end, "strip end without row end")
	`TSPP_ASSERT_NEXT(a_stall_holds_sel, clk, arst_n, v_s2 && !m_tready,
		v_s2 && $stable(sel_q), "byte pointer moved during stall")
	`TSPP_ASSERT_NOW(a_nibble_count, clk, arst_n, cfg_q.mode == MODE_NIBBLE,
		st_q.pix <= 3'd1, "nibble mode holds more than one pixel")

endmodule
`default_nettype wire

### dv/strip_byte_checker.sv
// Checker of the strip pixel packer: predicts strip bytes from accepted pixels and compares.
module strip_byte_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [7:0]                     s_tdata,
	input  logic                           s_tlast,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [7:0]                     m_tdata,
	input  logic                           m_tlast,
	input  logic [1:0]                     m_tuser,
	input  logic                           cfg_we,
	input  logic [tspp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tspp_pkg::CFG_W-1:0]     cfg_data,
	output int                             mismatch_count,
	output int                             bytes_due
);
	import tspp_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       row_end;
		logic       strip_end;
	} strip_byte_t;

	// Fixed colours, byte k of a colour at bits 8k+7..8k.
	localparam logic [31:0] CMYK_COLOURS [8] = '{
		32'h00000000, 32'h000000ff, 32'h0000ffff, 32'h0000ff00,
		32'h00ffff00, 32'h00ff0000, 32'h00ff00ff, 32'hff000000
	};
	localparam logic [23:0] RGB_COLOURS [8] = '{
		24'hffffff, 24'hffff00, 24'hff0000, 24'hff00ff,
		24'h0000ff, 24'h00ffff, 24'h00ff00, 24'h000000
	};
	localparam logic [7:0] COLOUR_LETTERS [8] = '{
		CODE_W, CODE_C, CODE_B, CODE_M, CODE_R, CODE_Y, CODE_G, CODE_K
	};

	logic [2:0]       mode;
	logic             ultra;
	logic             cmyk;
	logic [CFG_W-1:0] bg;
	logic [CFG_W-1:0] fg;
	logic [15:0]      strip_rows;
	logic [7:0]       acc;
	logic [2:0]       pix;
	logic [15:0]      rows;
	strip_byte_t      strip_q[$];

	function automatic logic [3:0] pixel_index(input logic [7:0] code);
		if (!ultra)
			return (code == CODE_ONE) ? IDX_PLAIN_FG : 4'd0;
		for (int i = 0; i < 8; i++)
			if (code == COLOUR_LETTERS[i])
				return 4'(i);
		return (code == CODE_ONE) ? IDX_ULTRA_FG : IDX_ULTRA_BG;
	endfunction

	function automatic logic [7:0] colour_byte(input logic [3:0] idx, input int k);
		int               alpha_at;
		logic [CFG_W-1:0] entry;
		alpha_at = cmyk ? 4 : 3;
		if (ultra && idx < IDX_ULTRA_BG) begin
			// Fixed colours take the foreground alpha and nothing above it.
			if (k == alpha_at)
				return fg[8*k +: 8];
			if (k > alpha_at)
				return 8'h00;
			return cmyk ? CMYK_COLOURS[idx[2:0]][8*k +: 8] : RGB_COLOURS[idx[2:0]][8*k +: 8];
		end
		if ((ultra && idx == IDX_ULTRA_FG) || (!ultra && idx == IDX_PLAIN_FG))
			entry = fg;
		else
			entry = bg;
		return entry[8*k +: 8];
	endfunction

	function automatic void pack_pixel(input logic [7:0] code, input logic row_in, input logic img);
		logic [3:0]  idx;
		logic        row_done;
		logic [15:0] rows_next;
		logic [7:0]  out_bytes[$];
		strip_byte_t item;
		idx = pixel_index(code);
		row_done = row_in || img;
		case (mode)
			MODE_BIT: begin
				acc = acc | (8'(idx[0]) << (3'd7 - pix));
				if (pix == 3'd7 || row_done) begin
					out_bytes.push_back(acc);
					acc = 8'h00;
					pix = 3'd0;
				end else begin
					pix = pix + 3'd1;
				end
			end
			MODE_NIBBLE: begin
				if (pix == 3'd0) begin
					acc = {idx, 4'h0};
					if (row_done) begin
						out_bytes.push_back(acc);
						acc = 8'h00;
					end else begin
						pix = 3'd1;
					end
				end else begin
					out_bytes.push_back(acc | 8'(idx));
					acc = 8'h00;
					pix = 3'd0;
				end
			end
			MODE_ALPHA: begin
				out_bytes.push_back(8'(idx));
				out_bytes.push_back(colour_byte(idx, cmyk ? 4 : 3));
			end
			MODE_QUAD: begin
				for (int k = 0; k < 4; k++)
					out_bytes.push_back(colour_byte(idx, k));
			end
			default: begin
				for (int k = 0; k < 5; k++)
					out_bytes.push_back(colour_byte(idx, k));
			end
		endcase
		foreach (out_bytes[i]) begin
			item = '0;
			item.data = out_bytes[i];
			if (i == out_bytes.size() - 1) begin
				item.last = 1'b1;
				if (row_done) begin
					item.row_end = 1'b1;
					rows_next = rows + 16'd1;
					if (img || rows_next >= strip_rows) begin
						item.strip_end = 1'b1;
						rows = 16'd0;
					end else begin
						rows = rows_next;
					end
				end
			end
			strip_q.push_back(item);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		strip_byte_t want;
		if (!arst_n) begin
			mode = MODE_BIT;
			ultra = 1'b0;
			cmyk = 1'b0;
			bg = '0;
			fg = '0;
			strip_rows = 16'd1;
			acc = 8'h00;
			pix = 3'd0;
			rows = 16'd0;
			strip_q.delete();
			mismatch_count = 0;
			bytes_due = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_PACK_MODE: begin
						// A mode change drops any partial byte.
						mode = cfg_data[2:0];
						acc = 8'h00;
						pix = 3'd0;
					end
					REG_ULTRA:      ultra = cfg_data[0];
					REG_CMYK:       cmyk = cfg_data[0];
					REG_BG_ENTRY:   bg = cfg_data;
					REG_FG_ENTRY:   fg = cfg_data;
					REG_ROWS_STRIP: strip_rows = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				pack_pixel(s_tdata, s_tlast, s_tuser);
			if (m_tvalid && m_tready) begin
				if (strip_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected byte %h last %b flags %b", $time,
							m_tdata, m_tlast, m_tuser);
				end else begin
					want = strip_q.pop_front();
					if (m_tdata !== want.data || m_tlast !== want.last ||
							m_tuser[0] !== want.row_end || m_tuser[1] !== want.strip_end) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display(
								"%0t: exp %h last %b row %b strip %b, got %h last %b row %b strip %b",
								$time, want.data, want.last, want.row_end, want.strip_end,
								m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
					end
				end
			end
			bytes_due = strip_q.size();
		end
	end

endmodule

### dv/testbench.sv
// Top of the strip pixel packer testbench: clock, reset, pixel stimulus and verdict.
module testbench;
	import tspp_pkg::*;

	localparam logic [2:0] MODE_OVERRANGE = 3'd7;
	localparam int LONG_STALL_CYCLES = 300;
	localparam int QUIET_CYCLES = 16;
	localparam logic [7:0] COLOUR_LETTERS [8] = '{
		CODE_W, CODE_C, CODE_B, CODE_M, CODE_R, CODE_Y, CODE_G, CODE_K
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = 8'h00;
	logic                 s_tlast = 1'b0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [7:0]           m_tdata;
	logic                 m_tlast;
	logic [1:0]           m_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	int mismatch_count;
	int bytes_due;
	int snd_idle_pct = 15;
	int rcv_idle_pct = 75;
	int stall_asks = 0;
	int stall_seen = 0;
	int stall_left = 0;
	int row_left = 4;

	always #1 clk = ~clk;

	tiff_strip_pixel_packer_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	strip_byte_checker byte_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.cfg_we         (cfg_we),
		.cfg_idx        (cfg_idx),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.bytes_due      (bytes_due)
	);

	// Receiver: random back-pressure, plus a long hold-off whenever one is requested.
	always @(posedge clk) begin
		if (stall_asks != stall_seen) begin
			stall_seen = stall_asks;
			stall_left = LONG_STALL_CYCLES;
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic send_pixel(input logic [7:0] code, input logic row, input logic img);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= code;
		s_tlast <= row;
		s_tuser <= img;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_random_pixel;
		logic [7:0] code;
		logic       row;
		logic       img;
		case ($urandom_range(9))
			0, 1:    code = 8'($urandom);
			2, 3:    code = CODE_ONE;
			4:       code = CODE_ZERO;
			default: code = COLOUR_LETTERS[$urandom_range(7)];
		endcase
		row_left--;
		row = (row_left == 0);
		img = 1'b0;
		if (row) begin
			row_left = $urandom_range(1, 12);
			// Image ends sometimes come without the row flag.
			if ($urandom_range(4) == 0) begin
				img = 1'b1;
				row = 1'($urandom_range(1));
			end
		end
		send_pixel(code, row, img);
	endtask

	// Hold the sender until every predicted byte has come out.
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bytes_due != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
	endtask

	task automatic end_writes;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Registers change only once the block has gone quiet; a held pixel may still be inside.
	task automatic setup(input logic [2:0] mode, input logic ultra, input logic cmyk,
			input logic [CFG_W-1:0] bg, input logic [CFG_W-1:0] fg, input logic [15:0] rps);
		drain();
		repeat (QUIET_CYCLES) @(posedge clk);
		write_reg(REG_PACK_MODE, CFG_W'(mode));
		write_reg(REG_ULTRA, CFG_W'(ultra));
		write_reg(REG_CMYK, CFG_W'(cmyk));
		write_reg(REG_BG_ENTRY, bg);
		write_reg(REG_FG_ENTRY, fg);
		write_reg(REG_ROWS_STRIP, CFG_W'(rps));
		end_writes();
	endtask

	function automatic logic [CFG_W-1:0] pick_entry;
		case ($urandom_range(5))
			0:       return '0;
			1:       return '1;
			default: return {8'($urandom), 32'($urandom)};
		endcase
	endfunction

	function automatic logic [15:0] pick_rows;
		case ($urandom_range(5))
			0:       return 16'd0;
			1:       return 16'd1;
			2:       return 16'hffff;
			default: return 16'($urandom_range(2, 4));
		endcase
	endfunction

	initial begin
		#400000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One-bit packing: a full byte, an image end without row end, then a short row.
		setup(MODE_BIT, 1'b0, 1'b0, '0, '1, 16'd1);
		for (int r = REG_ROWS_STRIP + 1; r < (1 << CFG_IDX_W); r++)
			write_reg(r[CFG_IDX_W-1:0], {8'($urandom), 32'($urandom)});
		end_writes();
		send_pixel(CODE_ONE, 1'b0, 1'b0);
		send_pixel(8'h00, 1'b0, 1'b0);
		send_pixel(8'hff, 1'b0, 1'b0);
		send_pixel(CODE_ONE, 1'b0, 1'b0);
		send_pixel(CODE_ONE, 1'b0, 1'b0);
		send_pixel(CODE_ZERO, 1'b0, 1'b0);
		send_pixel(CODE_ONE, 1'b0, 1'b0);
		send_pixel(CODE_ONE, 1'b0, 1'b0);
		send_pixel(CODE_ONE, 1'b0, 1'b1);
		send_pixel(CODE_ONE, 1'b0, 1'b0);
		send_pixel(CODE_ZERO, 1'b1, 1'b0);

		// Nibbles with wide ultra indices; zero rows per strip ends a strip on every row.
		setup(MODE_NIBBLE, 1'b1, 1'b1, pick_entry(), pick_entry(), 16'd0);
		send_pixel(CODE_K, 1'b0, 1'b0);
		send_pixel(CODE_ONE, 1'b0, 1'b0);
		send_pixel(CODE_W, 1'b1, 1'b0);

		setup(MODE_ALPHA, 1'b1, 1'b1, {8'($urandom), 32'($urandom)}, '1, 16'd2);
		send_pixel(CODE_ZERO, 1'b0, 1'b0);
		send_pixel(CODE_Y, 1'b1, 1'b0);

		setup(MODE_QUAD, 1'b0, 1'b0, '1, {8'($urandom), 32'($urandom)}, 16'd1);
		send_pixel(CODE_ONE, 1'b0, 1'b0);
		send_pixel(CODE_ZERO, 1'b1, 1'b0);

		setup(MODE_FULL, 1'b1, 1'b0, pick_entry(), '1, 16'hffff);
		send_pixel(CODE_R, 1'b0, 1'b0);
		send_pixel(CODE_C, 1'b1, 1'b0);

		// Out-of-range mode packs like five bytes; an unknown code falls to background.
		setup(MODE_OVERRANGE, 1'b1, 1'b1, '1, '0, 16'hffff);
		send_pixel(CODE_G, 1'b0, 1'b0);
		send_pixel(8'h80, 1'b0, 1'b1);

		for (int phase = 0; phase < 12; phase++) begin
			if (phase < 4) begin
				snd_idle_pct = 15;
				rcv_idle_pct = 75;
			end else if (phase < 8) begin
				snd_idle_pct = 75;
				rcv_idle_pct = 15;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			setup(($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7)),
				1'($urandom), 1'($urandom), pick_entry(), pick_entry(), pick_rows());
			for (int n = 0; n < 18; n++) begin
				if (phase == 2 && n == 5)
					stall_asks++;
				if (phase == 6 && n == 8)
					drain();
				send_random_pixel();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && bytes_due == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
